// ----- sv/ptw_pkg.sv -----
`default_nettype none
package ptw_pkg;
  localparam int STORE_WORDS = 65536;
  localparam int AW = $clog2(STORE_WORDS);
  localparam int QDEPTH = 2;

  localparam logic [1:0] MODE_TRANSLATE = 2'd0;
  localparam logic [1:0] MODE_MAP = 2'd1;
  localparam logic [1:0] MODE_UNMAP = 2'd2;
  localparam logic [1:0] MODE_PROTECT = 2'd3;

  localparam logic [1:0] REG_ACTIVE_ROOT = 2'd0;
  localparam logic [1:0] REG_POOL_BASE = 2'd1;
  localparam logic [1:0] REG_POOL_PAGES = 2'd2;

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_NONCANON = 4'd1;
  localparam logic [3:0] ST_UNALIGNED = 4'd2;
  localparam logic [3:0] ST_NULL = 4'd3;
  localparam logic [3:0] ST_ENCODE = 4'd4;
  localparam logic [3:0] ST_UNMAPPED = 4'd5;
  localparam logic [3:0] ST_LARGE = 4'd6;
  localparam logic [3:0] ST_EXHAUSTED = 4'd7;
  localparam logic [3:0] ST_UNCHANGED = 4'd8;

  localparam logic [63:0] FLAG_MASK = 64'h8000_0000_0000_01FE;

  typedef struct packed {
    logic [3:0]  pre_status;
    logic [1:0]  mode;
    logic [47:0] va;
    logic [39:0] pa_page;
    logic [63:0] flags;
    logic [39:0] root_page;
  } item_t;

  typedef struct packed {
    logic [51:0] active_root;
    logic [51:0] pool_base;
    logic [7:0]  pool_pages;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [51:0] translated;
    logic        invalidate;
  } res_t;

  function automatic logic [AW-1:0] word_addr(input logic [39:0] page, input logic [8:0] idx);
    logic [48:0] full;
    full = {page, idx};
    return full[AW-1:0];
  endfunction
endpackage
`default_nettype wire

// ----- sv/four_level_page_table_engine_top.sv -----
`default_nettype none
// A full four-level walk takes the item from the queue, then per level reads the store
// (S_LOOK) and evaluates the entry (S_EVAL); a request that fails the address checks
// gets its result registered when it is taken. Each table allocated by map is zeroed
// (S_ZERO) and then linked (S_LINK). One item is walked at a time, two more wait;
// the next starts once the result is popped.
// Reset (synchronous, active high) clears the 65536-word store; full stays high while it clears.
module four_level_page_table_engine_top
  import ptw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  mode,
  input  wire logic [63:0] virt_address,
  input  wire logic [63:0] phys_address,
  input  wire logic [63:0] entry_flags,
  input  wire logic [63:0] root_table,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       status,
  output logic [51:0]      translated,
  output logic             invalidate,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [51:0] cfg_data
);
  cfg_t  cfg;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;
  logic  clearing;
  logic  res_valid;
  res_t  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ACTIVE_ROOT: cfg.active_root <= cfg_data;
        REG_POOL_BASE: cfg.pool_base <= cfg_data;
        REG_POOL_PAGES: cfg.pool_pages <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ptw_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .mode(mode),
    .virt_address(virt_address), .phys_address(phys_address),
    .entry_flags(entry_flags), .root_table(root_table), .clearing(clearing),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  ptw_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_item(q_item),
    .q_pop(q_pop), .clearing(clearing), .res_valid(res_valid), .res(res),
    .res_pop(pop)
  );

  assign empty = !res_valid;
  assign status = res.status;
  assign translated = res.translated;
  assign invalidate = res.invalidate;
endmodule
`default_nettype wire

// ----- sv/ptw_front.sv -----
`default_nettype none
module ptw_front
  import ptw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  mode,
  input  wire logic [63:0] virt_address,
  input  wire logic [63:0] phys_address,
  input  wire logic [63:0] entry_flags,
  input  wire logic [63:0] root_table,
  input  wire logic        clearing,
  output logic             q_valid,
  output item_t            q_item,
  input  wire logic        q_pop
);
  localparam int PW = $clog2(QDEPTH);

  item_t               slots [QDEPTH];
  logic [PW-1:0]       wptr;
  logic [PW-1:0]       rptr;
  logic [PW:0]         count;
  item_t               item_in;
  logic                do_push;
  logic                do_pop;
  logic                canon;
  logic                unaligned;
  logic                enc_bad;

  always_comb begin
    canon = (virt_address[63:47] == '0) || (virt_address[63:47] == '1);
    unaligned = (root_table[11:0] != '0) ||
                (mode != MODE_TRANSLATE && virt_address[11:0] != '0) ||
                (mode == MODE_MAP && phys_address[11:0] != '0);
    enc_bad = (root_table[63:52] != '0) || (mode == MODE_MAP && phys_address[63:52] != '0);
    item_in.mode = mode;
    item_in.va = virt_address[47:0];
    item_in.pa_page = phys_address[51:12];
    item_in.flags = entry_flags & FLAG_MASK;
    item_in.root_page = root_table[51:12];
    if (!canon) begin
      item_in.pre_status = ST_NONCANON;
    end else if (unaligned) begin
      item_in.pre_status = ST_UNALIGNED;
    end else if (root_table == '0) begin
      item_in.pre_status = ST_NULL;
    end else if (enc_bad) begin
      item_in.pre_status = ST_ENCODE;
    end else begin
      item_in.pre_status = ST_OK;
    end
  end

  assign full = (count == (PW+1)'(QDEPTH)) || clearing;
  assign do_push = push && !full;
  assign q_valid = (count != '0);
  assign do_pop = q_pop && q_valid;
  assign q_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= item_in;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(QDEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(QDEPTH-1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end
endmodule
`default_nettype wire

// ----- sv/ptw_back.sv -----
`default_nettype none
module ptw_back
  import ptw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  q_valid,
  input  wire item_t q_item,
  output logic       q_pop,
  output logic       clearing,
  output logic       res_valid,
  output res_t       res,
  input  wire logic  res_pop
);
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_LOOK, S_EVAL, S_ZERO, S_LINK} state_t;

  state_t         state;
  logic [63:0]    mem [STORE_WORDS];
  logic [63:0]    rdata;
  logic [AW-1:0]  raddr;
  logic [AW-1:0]  waddr;
  logic [63:0]    wdata;
  logic           we;
  logic [AW-1:0]  clr_cnt;
  item_t          cur;
  logic [1:0]     lvl;
  logic [39:0]    table_page;
  logic [39:0]    new_page;
  logic [AW-1:0]  wptr;
  logic [8:0]     zcnt;
  logic [7:0]     pool_next;
  logic [8:0]     idx;
  logic [40:0]    np_sum;
  logic [63:0]    nw;
  logic           leaf_write;
  logic           inv_hit;
  logic [3:0]     ev_status;
  logic [51:0]    ev_trans;
  logic           ev_inv;
  logic           ev_alloc;
  logic           ev_descend;

  always_comb begin
    unique case (lvl)
      2'd3: idx = cur.va[47:39];
      2'd2: idx = cur.va[38:30];
      2'd1: idx = cur.va[29:21];
      default: idx = cur.va[20:12];
    endcase
    raddr = word_addr(table_page, idx);
    np_sum = {1'b0, cfg.pool_base[51:12]} + {33'b0, pool_next};
    inv_hit = ({cur.root_page, 12'b0} == cfg.active_root);
    nw = '0;
    leaf_write = 1'b0;
    case (cur.mode)
      MODE_MAP: begin
        nw = {12'b0, cur.pa_page, 12'b0} | cur.flags | 64'd1;
        leaf_write = 1'b1;
      end
      MODE_UNMAP: begin
        nw = '0;
        leaf_write = rdata[0];
      end
      MODE_PROTECT: begin
        nw = {12'b0, rdata[51:12], 12'b0} | cur.flags | 64'd1;
        leaf_write = rdata[0];
      end
      default: begin
        nw = '0;
        leaf_write = 1'b0;
      end
    endcase
    ev_status = ST_OK;
    ev_trans = '0;
    ev_inv = 1'b0;
    ev_alloc = 1'b0;
    ev_descend = 1'b0;
    if (lvl != 2'd0) begin
      if (!rdata[0]) begin
        if (cur.mode != MODE_MAP) begin
          ev_status = ST_UNMAPPED;
        end else if (pool_next >= cfg.pool_pages) begin
          ev_status = ST_EXHAUSTED;
        end else if (np_sum[40]) begin
          ev_status = ST_ENCODE;
        end else begin
          ev_alloc = 1'b1;
        end
      end else if (rdata[7]) begin
        ev_status = ST_LARGE;
      end else begin
        ev_descend = 1'b1;
      end
    end else if (cur.mode != MODE_MAP && !rdata[0]) begin
      ev_status = ST_UNMAPPED;
    end else if (cur.mode == MODE_TRANSLATE) begin
      ev_trans = {rdata[51:12], cur.va[11:0]};
    end else if (nw == rdata) begin
      ev_status = ST_UNCHANGED;
    end else begin
      ev_inv = inv_hit;
    end
    we = 1'b0;
    waddr = wptr;
    wdata = '0;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        waddr = clr_cnt;
      end
      S_ZERO: begin
        we = 1'b1;
        waddr = word_addr(new_page, zcnt);
      end
      S_LINK: begin
        we = 1'b1;
        wdata = {12'b0, new_page, 12'b0} | 64'd3 | (cur.flags & 64'd4);
      end
      S_EVAL: begin
        we = (lvl == 2'd0) && leaf_write && (nw != rdata);
        wdata = nw;
      end
      default: we = 1'b0;
    endcase
  end

  assign clearing = (state == S_CLEAR);
  assign q_pop = (state == S_IDLE) && q_valid && !res_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      pool_next <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_pop) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            cur <= q_item;
            table_page <= q_item.root_page;
            lvl <= 2'd3;
            if (q_item.pre_status != ST_OK) begin
              res <= '{status: q_item.pre_status, translated: '0, invalidate: 1'b0};
              res_valid <= 1'b1;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          wptr <= raddr;
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (ev_alloc) begin
            pool_next <= pool_next + 1'b1;
            new_page <= np_sum[39:0];
            zcnt <= '0;
            state <= S_ZERO;
          end else if (ev_descend) begin
            table_page <= rdata[51:12];
            lvl <= lvl - 1'b1;
            state <= S_LOOK;
          end else begin
            state <= S_IDLE;
            res_valid <= 1'b1;
            res <= '{status: ev_status, translated: ev_trans, invalidate: ev_inv};
          end
        end
        S_ZERO: begin
          zcnt <= zcnt + 1'b1;
          if (zcnt == '1) begin
            state <= S_LINK;
          end
        end
        S_LINK: begin
          table_page <= new_page;
          lvl <= lvl - 1'b1;
          state <= S_LOOK;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
